[rtl/core/ils_pkg.sv]
// ----------------------------------------------------------------------------
// ils_pkg
// Shared command codes, status codes and fixed field widths for the indexed
// list store.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

   // Fixed widths of the transaction fields.
   localparam int CMD_W    = 2;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [STATUS_W-1:0] status_type;

endpackage

`default_nettype wire

[rtl/core/indexed_list_store_top.sv]
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Bounded list of signed 32-bit words with a live count, held in one RAM.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the req_ channel (valid/stall) and each produces
// exactly one transaction on the rsp_ channel with a status, the read word
// (zero unless a read succeeds) and the live count after the command.
// Append and update, and every rejected command, give their result in the
// cycle after acceptance, and a new command can be taken every cycle while
// the result register is free or being emptied, so these run at one per cycle.
// A read waits on the RAM's registered read port: the word is loaded into the
// result register from the read state, and the next command is taken back in idle.
// An erase at position p with count n moves n-1-p words through the single
// RAM read port, one per cycle, and the request channel is stalled while the
// tail is walked.
// A result waits in the output register while rsp_stall is high; the next
// command is then held off until the result is taken.
// Reset clears the live count, so the list is empty; the RAM needs no clear
// because only written entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store_top #(
   parameter int DEPTH = 256,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CntW  = $clog2(DEPTH + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [ils_pkg::CMD_W-1:0]    req_command,
   input  wire logic [ils_pkg::POS_W-1:0]    req_position,
   input  wire logic signed [ils_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [ils_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [ils_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [CntW-1:0]                   rsp_count
);

   logic               ram_wr_en;
   logic [AddrW-1:0]   ram_wr_addr;
   ils_pkg::value_type ram_wr_data;
   logic               ram_rd_en;
   logic [AddrW-1:0]   ram_rd_addr;
   ils_pkg::value_type ram_rd_data;
   ils_pkg::value_type rsp_word;

   // Command sequencer and result register.
   ils_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_value      (ils_pkg::value_type'(req_value)),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_word),
      .rsp_count      (rsp_count),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   assign rsp_read_value = signed'(rsp_word);

   // Element storage.
   ils_ram #(
      .WIDTH (ils_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

[rtl/core/ils_ram.sv]
// ----------------------------------------------------------------------------
// ils_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/ils_ctrl.sv]
// ----------------------------------------------------------------------------
// ils_ctrl
// Command sequencer for the indexed list store: checks each command against
// the live count, drives the element RAM, walks the tail on an erase and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ctrl #(
   parameter int DEPTH = 256,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CntW  = $clog2(DEPTH + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Request channel.
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [ils_pkg::CMD_W-1:0]    req_command,
   input  wire logic [ils_pkg::POS_W-1:0]    req_position,
   input  wire ils_pkg::value_type           req_value,
   // Result channel.
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output ils_pkg::status_type               rsp_status,
   output ils_pkg::value_type                rsp_read_value,
   output logic [CntW-1:0]                   rsp_count,
   // Element RAM.
   output logic                              ram_wr_en,
   output logic [AddrW-1:0]                  ram_wr_addr,
   output ils_pkg::value_type                ram_wr_data,
   output logic                              ram_rd_en,
   output logic [AddrW-1:0]                  ram_rd_addr,
   input  wire ils_pkg::value_type           ram_rd_data
);

   // Compare width: wide enough for a position, a count and one more.
   localparam int CmpW = (CntW > ils_pkg::POS_W) ? CntW + 1 : ils_pkg::POS_W + 1;

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_ERASE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [AddrW-1:0]    rd_ptr_ff, rd_ptr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   ils_pkg::status_type rsp_status_ff;
   ils_pkg::value_type  rsp_read_value_ff;
   logic [CntW-1:0]     rsp_count_ff;

   logic                accept;
   logic                load;
   ils_pkg::status_type ld_status;
   ils_pkg::value_type  ld_value;
   logic [CntW-1:0]     ld_count;

   logic [CmpW-1:0]     pos_ext;
   logic [CmpW-1:0]     pos_next_ext;
   logic [CmpW-1:0]     cnt_ext;
   logic [CntW-1:0]     ptr_next;
   logic                full;

   // A new transaction is taken only in idle and when the result register is
   // free or being emptied in this cycle.
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign pos_ext      = CmpW'(req_position);
   assign pos_next_ext = pos_ext + CmpW'(1);
   assign cnt_ext      = CmpW'(count_ff);
   assign ptr_next     = CntW'(rd_ptr_ff) + CntW'(1);
   assign full         = (count_ff == CntW'(DEPTH));

   // Command decode, RAM control and tail walk.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = AddrW'(count_ff);
      ram_wr_data = req_value;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AddrW'(pos_ext);
      load        = 1'b0;
      ld_status   = ils_pkg::STATUS_OK;
      ld_value    = '0;
      ld_count    = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_command)
                  ils_pkg::CMD_APPEND: begin
                     load = 1'b1;
                     if (full) begin
                        ld_status = ils_pkg::STATUS_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CntW'(1);
                        ld_count  = count_ff + CntW'(1);
                     end
                  end
                  ils_pkg::CMD_READ: begin
                     if (pos_ext >= cnt_ext) begin
                        load      = 1'b1;
                        ld_status = ils_pkg::STATUS_RANGE;
                     end else begin
                        ram_rd_en = 1'b1;
                        state_in  = S_READ;
                     end
                  end
                  ils_pkg::CMD_UPDATE: begin
                     load = 1'b1;
                     if (pos_ext >= cnt_ext) begin
                        ld_status = ils_pkg::STATUS_RANGE;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AddrW'(pos_ext);
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        load      = 1'b1;
                        ld_status = ils_pkg::STATUS_EMPTY;
                     end else if (pos_ext >= cnt_ext) begin
                        load      = 1'b1;
                        ld_status = ils_pkg::STATUS_RANGE;
                     end else if (pos_next_ext == cnt_ext) begin
                        // The last entry goes: nothing to shift.
                        load     = 1'b1;
                        count_in = count_ff - CntW'(1);
                        ld_count = count_ff - CntW'(1);
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AddrW'(pos_next_ext);
                        rd_ptr_in   = AddrW'(pos_next_ext);
                        state_in    = S_ERASE;
                     end
                  end
               endcase
            end
         end

         S_READ: begin
            load     = 1'b1;
            ld_value = ram_rd_data;
            state_in = S_IDLE;
         end

         S_ERASE: begin
            // Move the word just read down by one place.
            ram_wr_en   = 1'b1;
            ram_wr_addr = rd_ptr_ff - AddrW'(1);
            ram_wr_data = ram_rd_data;
            if (ptr_next < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AddrW'(ptr_next);
               rd_ptr_in   = AddrW'(ptr_next);
            end else begin
               load     = 1'b1;
               count_in = count_ff - CntW'(1);
               ld_count = count_ff - CntW'(1);
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The result register is either loaded or kept while the receiver stalls.
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      if (load) begin
         rsp_status_ff     <= ld_status;
         rsp_read_value_ff <= ld_value;
         rsp_count_ff      <= ld_count;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

`default_nettype wire
